// ===== src/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg: shared types and constants for the hex ring cell generator
// Direction table, field widths and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int CENTER_BITS    = 8;
    localparam int CELL_BITS      = 10;
    localparam int RING_BITS      = 3;
    localparam int DIR_BITS       = 3;
    localparam int S_DATA_BITS    = 24;
    localparam int M_DATA_BITS    = 24;
    localparam int DEF_MAX_RADIUS = 4;
    localparam int DEF_COORD_BITS = 8;

    localparam logic [DIR_BITS-1:0] LAST_DIR = 3'd5;

    typedef logic [CELL_BITS-1:0] cell_t;

    typedef struct packed {
        logic load;       // start a run from the input word
        logic next_ring;  // jump to the start cell of the next ring
        logic step;       // walk one cell along the current ring
    } hrc_cmd_t;

    typedef struct packed {
        logic range_empty;  // input word asks for no rings
        logic ring_end;     // current cell is the last one of its ring
        logic run_last;     // current cell is the last one of the run
    } hrc_sts_t;

    // Column change per direction: -1, 0, +1, +1, 0, -1
    function automatic cell_t hrc_col_delta(input logic [DIR_BITS-1:0] dir);
        cell_t d;
        case (dir)
            3'd1, 3'd4: d = '0;
            3'd2, 3'd3: d = cell_t'(1);
            default:    d = '1;
        endcase
        return d;
    endfunction

    // Row change per direction; diagonals depend on the column parity
    function automatic cell_t hrc_row_delta(input logic [DIR_BITS-1:0] dir,
                                            input logic odd);
        cell_t d;
        case (dir)
            3'd1:       d = cell_t'(1);
            3'd4:       d = '1;
            3'd2:       d = odd ? cell_t'(1) : '0;
            3'd3, 3'd5: d = odd ? '0 : '1;
            default:    d = odd ? cell_t'(1) : '0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/hex_ring_cell_generator.sv =====
// ----------------------------------------------------------------------------
// hex_ring_cell_generator: hex grid ring walker, column-offset coordinates
// Emits every cell of rings from_radius..to_radius around a center cell.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per run: center column/row and an
//   inclusive radius range (each bound clamped to MAX_RADIUS). The master
//   channel returns one word per cell: column, row (10-bit two's complement),
//   the ring radius, and tlast on the final cell of the run. A zero radius
//   yields the center cell once; an empty range yields nothing.
//   Latency: the first cell is valid the cycle after the input word is taken.
//   Throughput: one cell per cycle while m_tready is high; a run of N cells
//   holds the block from the input word through its last cell, N up to 61 at
//   MAX_RADIUS = 4. The input side is ready only between runs, since the
//   walk registers double as the output register.
//   A stall on m_tready freezes the walk; the current cell stays presented.
//   Reset (aresetn low, synchronous) returns to idle, ready for input, with
//   no output word valid.
// ----------------------------------------------------------------------------
module hex_ring_cell_generator
    import hrc_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] hub_col, [15:8] hub_row, [18:16] from_radius, [21:19] to_radius
    input  logic [S_DATA_BITS-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [9:0] cell_x, [19:10] cell_y, [22:20] ring
    output logic [M_DATA_BITS-1:0] m_tdata,
    output logic                   m_tlast
);

    hrc_cmd_t cmd;
    hrc_sts_t sts;

    hrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hrc_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

    assign m_tlast = sts.run_last;

endmodule

// ===== src/hrc_datapath.sv =====
// ----------------------------------------------------------------------------
// hrc_datapath: walk position, ring and direction counters
// Holds the current cell, which is also the output word, and flags ring ends.
// ----------------------------------------------------------------------------
module hrc_datapath
    import hrc_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  hrc_cmd_t               cmd,
    output hrc_sts_t               sts,
    output logic [M_DATA_BITS-1:0] m_tdata
);

    localparam int CB = (COORD_BITS < CENTER_BITS) ? COORD_BITS : CENTER_BITS;
    localparam logic [CENTER_BITS-1:0] CMASK =
        CENTER_BITS'((CENTER_BITS+1)'(1) << CB) - CENTER_BITS'(1);
    localparam logic [RING_BITS-1:0] RMAX = RING_BITS'(MAX_RADIUS);

    logic [CENTER_BITS-1:0] in_x, in_y;
    logic [RING_BITS-1:0]   lo_raw, hi_raw, lo_c, hi_c;

    logic [CENTER_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    cell_t                  walk_x_reg, walk_x_next, walk_y_reg, walk_y_next;
    logic [RING_BITS-1:0]   ring_reg, ring_next, hi_reg, hi_next, ring_inc;
    logic [DIR_BITS-1:0]    dir_reg, dir_next;
    logic [RING_BITS-1:0]   step_reg, step_next, step_inc;

    assign in_x   = s_tdata[7:0] & CMASK;
    assign in_y   = s_tdata[15:8] & CMASK;
    assign lo_raw = s_tdata[18:16];
    assign hi_raw = s_tdata[21:19];
    assign lo_c   = (lo_raw > RMAX) ? RMAX : lo_raw;
    assign hi_c   = (hi_raw > RMAX) ? RMAX : hi_raw;

    assign ring_inc = ring_reg + RING_BITS'(1);
    assign step_inc = step_reg + RING_BITS'(1);

    always_comb begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        hi_next     = hi_reg;
        ring_next   = ring_reg;
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        dir_next    = dir_reg;
        step_next   = step_reg;
        if (cmd.load) begin
            cx_next     = in_x;
            cy_next     = in_y;
            hi_next     = hi_c;
            ring_next   = lo_c;
            walk_x_next = cell_t'(in_x);
            walk_y_next = cell_t'(in_y) - cell_t'(lo_c);
            dir_next    = '0;
            step_next   = '0;
        end else if (cmd.next_ring) begin
            ring_next   = ring_inc;
            walk_x_next = cell_t'(cx_reg);
            walk_y_next = cell_t'(cy_reg) - cell_t'(ring_inc);
            dir_next    = '0;
            step_next   = '0;
        end else if (cmd.step) begin
            walk_x_next = walk_x_reg + hrc_col_delta(dir_reg);
            walk_y_next = walk_y_reg + hrc_row_delta(dir_reg, walk_x_reg[0]);
            if (step_inc == ring_reg) begin
                dir_next  = dir_reg + DIR_BITS'(1);
                step_next = '0;
            end else begin
                step_next = step_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= '0;
            hi_reg   <= '0;
            dir_reg  <= '0;
            step_reg <= '0;
        end else begin
            ring_reg <= ring_next;
            hi_reg   <= hi_next;
            dir_reg  <= dir_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        walk_x_reg <= walk_x_next;
        walk_y_reg <= walk_y_next;
    end

    assign sts.range_empty = lo_c > hi_c;
    assign sts.ring_end    = (ring_reg == '0) ||
                             ((dir_reg == LAST_DIR) && (step_inc == ring_reg));
    assign sts.run_last    = sts.ring_end && (ring_reg == hi_reg);

    assign m_tdata = {1'b0, ring_reg, walk_y_reg, walk_x_reg};

endmodule

// ===== src/hrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrc_ctrl: run sequencer
// Takes one input word when idle, then steps the datapath once per output word.
// ----------------------------------------------------------------------------
module hrc_ctrl
    import hrc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  hrc_sts_t sts,
    output hrc_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic in_acc, out_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RUN);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    assign cmd.load      = in_acc;
    assign cmd.next_ring = out_acc && sts.ring_end && !sts.run_last;
    assign cmd.step      = out_acc && !sts.ring_end;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && !sts.range_empty) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (out_acc && sts.run_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.next_ring, cmd.step}))
        else $error("hrc_ctrl: more than one datapath command");

    a_run_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && sts.run_last |=> state_reg == ST_IDLE)
        else $error("hrc_ctrl: run did not end after last word");

    a_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && sts.range_empty |=> state_reg == ST_IDLE)
        else $error("hrc_ctrl: empty range started a run");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("hrc_ctrl: run dropped while output stalled");
`endif

endmodule

// ===== tb/hrc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_tb_pkg: ring walk predictor and cell scoreboard
// Works out every cell of a run from the accepted input word and checks the
// cell words from the master channel against them, oldest first.
// ----------------------------------------------------------------------------
package hrc_tb_pkg;
    import hrc_pkg::*;

    localparam int TB_MAX_RADIUS = DEF_MAX_RADIUS;

    // Walk directions in ring order, as (dx, dy)
    typedef enum logic [DIR_BITS-1:0] {
        DIR_LEFT_DOWN  = 3'd0,  // (-1, +1 in odd columns, else 0)
        DIR_DOWN       = 3'd1,  // ( 0, +1)
        DIR_RIGHT_DOWN = 3'd2,  // (+1, +1 in odd columns, else 0)
        DIR_RIGHT_UP   = 3'd3,  // (+1, -1 in even columns, else 0)
        DIR_UP         = 3'd4,  // ( 0, -1)
        DIR_LEFT_UP    = 3'd5   // (-1, -1 in even columns, else 0)
    } heading_t;

    typedef struct packed {
        cell_t                col;
        cell_t                row;
        logic [RING_BITS-1:0] ring;
        logic                 last_cell;
    } ring_cell_t;

    class hex_ring_scoreboard;
        cell_t                pos_x;
        cell_t                pos_y;
        logic [RING_BITS-1:0] cur_ring;
        heading_t             heading;
        logic [2:0]           steps_done;
        ring_cell_t           pending_cells[$];
        int                   mismatch_count;

        function new();
            pos_x          = '0;
            pos_y          = '0;
            cur_ring       = '0;
            heading        = DIR_LEFT_DOWN;
            steps_done     = '0;
            mismatch_count = 0;
        endfunction

        function void emit_cell();
            ring_cell_t c;
            c.col       = pos_x;
            c.row       = pos_y;
            c.ring      = cur_ring;
            c.last_cell = 1'b0;
            pending_cells = {pending_cells, c};
        endfunction

        // One step along the ring; diagonal row change follows column parity
        function void walk_one();
            logic odd;
            odd = pos_x[0];
            case (heading)
                DIR_DOWN:                      pos_y = pos_y + cell_t'(1);
                DIR_UP:                        pos_y = pos_y - cell_t'(1);
                DIR_LEFT_DOWN, DIR_RIGHT_DOWN: pos_y = pos_y + cell_t'(odd);
                default:                       pos_y = pos_y - cell_t'(!odd);
            endcase
            case (heading)
                DIR_LEFT_DOWN, DIR_LEFT_UP:  pos_x = pos_x - cell_t'(1);
                DIR_RIGHT_DOWN, DIR_RIGHT_UP: pos_x = pos_x + cell_t'(1);
                default: ;
            endcase
        endfunction

        function void note_run(input logic [S_DATA_BITS-1:0] word);
            logic [RING_BITS-1:0] lo;
            logic [RING_BITS-1:0] hi;
            int                   n_before;
            lo = word[18:16];
            hi = word[21:19];
            if (lo > TB_MAX_RADIUS) lo = RING_BITS'(TB_MAX_RADIUS);
            if (hi > TB_MAX_RADIUS) hi = RING_BITS'(TB_MAX_RADIUS);
            n_before = pending_cells.size();
            for (int r = lo; r <= hi; r++) begin
                cur_ring   = RING_BITS'(r);
                pos_x      = cell_t'(word[7:0]);
                pos_y      = cell_t'(word[15:8]) - cell_t'(r);
                heading    = DIR_LEFT_DOWN;
                steps_done = '0;
                emit_cell();
                if (r == 0) continue;  // zero radius: center only
                while (!(heading == DIR_LEFT_UP && steps_done == r - 1)) begin
                    walk_one();
                    emit_cell();
                    steps_done++;
                    if (steps_done == r) begin
                        heading    = heading_t'(heading + 1);
                        steps_done = '0;
                    end
                end
            end
            if (pending_cells.size() > n_before)
                pending_cells[$].last_cell = 1'b1;
        endfunction

        function void check_cell(input logic [M_DATA_BITS-1:0] data, input logic tlast);
            ring_cell_t want;
            if (pending_cells.size() == 0) begin
                $error("cell word with none expected: tdata=%h tlast=%b", data, tlast);
                mismatch_count++;
                return;
            end
            want = pending_cells.pop_front();
            if (data[9:0] !== want.col) begin
                $error("cell_x: expected %0d, got %0d", $signed(want.col), $signed(data[9:0]));
                mismatch_count++;
            end
            if (data[19:10] !== want.row) begin
                $error("cell_y: expected %0d, got %0d", $signed(want.row),
                       $signed(data[19:10]));
                mismatch_count++;
            end
            if (data[22:20] !== want.ring) begin
                $error("ring: expected %0d, got %0d", want.ring, data[22:20]);
                mismatch_count++;
            end
            if (tlast !== want.last_cell) begin
                $error("last_cell: expected %b, got %b", want.last_cell, tlast);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_hex_ring_cell_generator.sv =====
// ----------------------------------------------------------------------------
// tb_hex_ring_cell_generator: self-checking bench for the hex ring walker
// Sends directed and random run requests with random gaps and back-pressure,
// predicts every ring cell, and checks each cell word in order.
// ----------------------------------------------------------------------------
module tb_hex_ring_cell_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import hrc_pkg::*;
    import hrc_tb_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 70;
    localparam int RANDOM_RUNS     = 92;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic                   m_tlast;

    bit steady;    // no idling on either side
    bit hold_req;  // ask the receiver for one long hold-off

    hex_ring_scoreboard sb;

    hex_ring_cell_generator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 30) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_run(input logic [7:0] cx, input logic [7:0] cy,
                            input logic [2:0] lo, input logic [2:0] hi);
        logic [S_DATA_BITS-1:0] word;
        int                     gap;
        word = {2'b00, hi, lo, cy, cx};
        gap  = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_run(word);
    endtask

    function automatic logic [7:0] pick_coord();
        logic [7:0] edges [4];
        edges = '{8'd0, 8'd1, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: ready stretches broken by gaps, plus one long hold-off
    initial begin
        int stretch;
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            stretch = $urandom_range(1, 24);
            repeat (stretch - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_cell(m_tdata, m_tlast);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_hex_ring_cell_generator failed");
        $finish;
    end

    initial begin
        logic [2:0] lo;
        logic [2:0] hi;
        int         kind;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;
        hold_req = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero radius, empty and oversized ranges
        push_run(8'd0,   8'd0,   3'd0, 3'd0);
        push_run(8'd255, 8'd255, 3'd0, 3'd0);
        push_run(8'd0,   8'd0,   3'd4, 3'd4);   // walk goes negative
        push_run(8'd255, 8'd255, 3'd4, 3'd4);   // walk past 255
        push_run(8'd0,   8'd255, 3'd0, 3'd4);   // longest run
        push_run(8'd255, 8'd0,   3'd1, 3'd4);
        push_run(8'd1,   8'd10,  3'd1, 3'd2);   // odd center column
        push_run(8'd2,   8'd10,  3'd1, 3'd2);   // even center column
        push_run(8'd100, 8'd100, 3'd3, 3'd2);   // empty range
        push_run(8'd100, 8'd100, 3'd4, 3'd0);
        push_run(8'd50,  8'd60,  3'd7, 3'd7);   // both bounds clamped
        push_run(8'd50,  8'd60,  3'd5, 3'd6);
        push_run(8'd170, 8'd85,  3'd0, 3'd7);
        push_run(8'd85,  8'd170, 3'd6, 3'd1);   // clamped low bound above high
        push_run(8'd254, 8'd128, 3'd2, 3'd3);
        push_run(8'd128, 8'd1,   3'd1, 3'd1);
        push_run(8'd15,  8'd240, 3'd2, 3'd2);
        push_run(8'd240, 8'd15,  3'd3, 3'd3);

        for (int i = 0; i < RANDOM_RUNS; i++) begin
            if (i == 40) hold_req = 1'b1;
            steady = (i >= 70 && i < 86);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                lo = 3'($urandom_range(0, 4));
                hi = 3'($urandom_range(lo, 4));
            end else if (kind < 80) begin
                hi = 3'($urandom_range(0, 3));
                lo = 3'($urandom_range(hi + 1, 4));
            end else begin
                lo = 3'($urandom_range(0, 7));
                hi = 3'($urandom_range(0, 7));
            end
            push_run(pick_coord(), pick_coord(), lo, hi);
        end
        steady = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0)
            $display("tb_hex_ring_cell_generator passed");
        else
            $display("tb_hex_ring_cell_generator failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/hrc_pkg.sv
src/hrc_datapath.sv
src/hrc_ctrl.sv
src/hex_ring_cell_generator.sv
tb/hrc_tb_pkg.sv
tb/tb_hex_ring_cell_generator.sv
